// File: hdl/nnis_pkg.sv
// Shared constants, state codes and helper function of the nearest-neighbor scaler.
package nnis_pkg;

  localparam int MaxDim      = 256;
  localparam int StoreDepth  = 65536;
  localparam int DIM_W       = 9;
  localparam int COORD_W     = 8;
  localparam int PIX_W       = 8;
  localparam int LOAD_IDX_W  = 16;
  localparam int STORE_AW    = $clog2(StoreDepth);
  localparam int CFG_IDX_W   = 8;
  localparam int DIVIDEND_W  = COORD_W + DIM_W;
  localparam int PROD_W      = 2 * DIM_W;
  localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 8'd3;

  // Operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Sequencer states.
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] ST_WRITE = 3'd1;
  localparam logic [ST_W-1:0] ST_CHECK = 3'd2;
  localparam logic [ST_W-1:0] ST_DIVR  = 3'd3;
  localparam logic [ST_W-1:0] ST_DIVC  = 3'd4;
  localparam logic [ST_W-1:0] ST_ADDR  = 3'd5;
  localparam logic [ST_W-1:0] ST_READ  = 3'd6;

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MaxDim);
  localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(1);

  // A zero size is taken as one, anything above the maximum saturates.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_MIN;
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: hdl/nnis_ram.sv
// Generic single-port RAM with registered read data.
module nnis_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/nnis_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
module nnis_div
  import nnis_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIM_W-1:0]      divisor_i,
  output logic                  done_o,
  output logic [COORD_W-1:0]    quotient_o
);

  logic [DIM_W-1:0]      rem_q, rem_d;
  logic [DIVIDEND_W-1:0] num_q, num_d;
  logic [DIM_W-1:0]      div_q, div_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic                  run_q, run_d;
  logic                  done_q, done_d;
  logic [DIM_W:0]        trial;
  logic                  fits;

  assign trial = {rem_q, num_q[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      num_d = dividend_i;
      div_d = divisor_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      // The remainder stays below the divisor, so it fits in DIM_W bits.
      rem_d = fits ? DIM_W'(trial - {1'b0, div_q}) : trial[DIM_W-1:0];
      num_d = {num_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = num_q[COORD_W-1:0];

endmodule

// File: hdl/nearest_neighbor_image_scaler_core.sv
// Top level of the nearest-neighbor scaler: sequencer, shared multiplier and frame store.
//
// Use: configuration registers (source width/height, target width/height, indexes
// 0..3) are written over the cfg_valid_i/cfg_ready_o channel while the block is
// idle; cfg_ready_o is always high, and writes to other indexes are ignored.
// A command is taken when start is high and busy is low. A load (operation 0)
// writes load_pixel_i to the frame store at load_index_i and gives no result;
// it keeps busy high for one cycle. A read (operation 1) gives one result on
// out_pixel_o and out_of_range_o, marked by a one-cycle done_o pulse.
// A read outside the target size answers from the range check, without dividing. Any other
// read scales each target coordinate with the shared multiplier and two divisions in one
// bit-serial divider, one quotient bit a cycle over a 17-bit dividend, then forms the
// store address and reads the frame store. One command is in flight at a time.
// Reset clears the sequencer and sets all four sizes to 256; the frame store is
// not cleared, so a read must only reach pixels that were loaded.
// The receiver cannot stall: each result is shown for exactly one cycle.
module nearest_neighbor_image_scaler_core
  import nnis_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [DIM_W-1:0]      cfg_data_i,
  input  logic                  start,
  output logic                  busy,
  input  logic                  operation_i,
  input  logic [LOAD_IDX_W-1:0] load_index_i,
  input  logic [PIX_W-1:0]      load_pixel_i,
  input  logic [COORD_W-1:0]    target_row_i,
  input  logic [COORD_W-1:0]    target_col_i,
  output logic                  done_o,
  output logic [PIX_W-1:0]      out_pixel_o,
  output logic                  out_of_range_o
);

  logic [ST_W-1:0]       state_q, state_d;
  logic [DIM_W-1:0]      src_w_q, src_h_q, tgt_w_q, tgt_h_q;
  logic [LOAD_IDX_W-1:0] load_index_q;
  logic [PIX_W-1:0]      load_pixel_q;
  logic [COORD_W-1:0]    row_q, col_q, srow_q, srow_d;
  logic                  done_q, done_d;
  logic                  oor_q, oor_d;
  logic [PIX_W-1:0]      pixel_q, pixel_d;

  logic [DIM_W-1:0]      mul_a, mul_b;
  logic [PROD_W-1:0]     product;
  logic [PROD_W-1:0]     addr_sum;

  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIM_W-1:0]      div_divisor;
  logic                  div_done;
  logic [COORD_W-1:0]    div_quot;

  logic                  ram_en, ram_we;
  logic [STORE_AW-1:0]   ram_addr;
  logic [PIX_W-1:0]      ram_rdata;
  logic                  accept;

  assign accept      = start && !busy;
  assign busy        = state_q != ST_IDLE;
  assign cfg_ready_o = 1'b1;

  // One multiplier serves both scale products and the raster address.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_CHECK: begin
        mul_a = {1'b0, row_q};
        mul_b = src_h_q;
      end
      ST_DIVR: begin
        mul_a = {1'b0, col_q};
        mul_b = src_w_q;
      end
      ST_ADDR: begin
        mul_a = {1'b0, srow_q};
        mul_b = src_w_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product  = mul_a * mul_b;
  assign addr_sum = product + PROD_W'(div_quot);

  always_comb begin
    state_d      = state_q;
    srow_d       = srow_q;
    done_d       = 1'b0;
    oor_d        = oor_q;
    pixel_d      = pixel_q;
    div_start    = 1'b0;
    div_dividend = product[DIVIDEND_W-1:0];
    div_divisor  = tgt_h_q;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = addr_sum[STORE_AW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (operation_i == OP_LOAD) ? ST_WRITE : ST_CHECK;
        end
      end
      ST_WRITE: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = load_index_q[STORE_AW-1:0];
        state_d  = ST_IDLE;
      end
      ST_CHECK: begin
        if ({1'b0, row_q} >= tgt_h_q || {1'b0, col_q} >= tgt_w_q) begin
          done_d  = 1'b1;
          oor_d   = 1'b1;
          pixel_d = '0;
          state_d = ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIVR;
        end
      end
      ST_DIVR: begin
        if (div_done) begin
          // The row quotient is taken; the column division starts at once.
          srow_d      = div_quot;
          div_start   = 1'b1;
          div_divisor = tgt_w_q;
          state_d     = ST_DIVC;
        end
      end
      ST_DIVC: begin
        if (div_done) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        ram_en  = 1'b1;
        state_d = ST_READ;
      end
      ST_READ: begin
        done_d  = 1'b1;
        oor_d   = 1'b0;
        pixel_d = ram_rdata;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      src_w_q <= DIM_MAX;
      src_h_q <= DIM_MAX;
      tgt_w_q <= DIM_MAX;
      tgt_h_q <= DIM_MAX;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SOURCE_WIDTH:  src_w_q <= clamp_dim(cfg_data_i);
          CFG_SOURCE_HEIGHT: src_h_q <= clamp_dim(cfg_data_i);
          CFG_TARGET_WIDTH:  tgt_w_q <= clamp_dim(cfg_data_i);
          CFG_TARGET_HEIGHT: tgt_h_q <= clamp_dim(cfg_data_i);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      load_index_q <= load_index_i;
      load_pixel_q <= load_pixel_i;
      row_q        <= target_row_i;
      col_q        <= target_col_i;
    end
    srow_q  <= srow_d;
    oor_q   <= oor_d;
    pixel_q <= pixel_d;
  end

  nnis_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  nnis_ram #(
    .Width (PIX_W),
    .Depth (StoreDepth)
  ) u_frame_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (load_pixel_q),
    .rdata_o (ram_rdata)
  );

  assign done_o         = done_q;
  assign out_pixel_o    = pixel_q;
  assign out_of_range_o = oor_q;

endmodule
